// File: rtl/core/fam_pkg.sv
// fam_pkg: shared widths, constants and types of the arming and motor mixer block
`timescale 1ns / 1ps

package fam_pkg;

    // motor slots and default motor count
    localparam int MOTOR_SLOTS         = 4;
    localparam int MOTOR_COUNT_DEFAULT = 4;
    localparam int SLOT_IDX_W          = 2;

    // field widths
    localparam int THR_W       = 14;
    localparam int SUM_W       = 16;
    localparam int LIM_W       = 10;
    localparam int SCALE_W     = 8;
    localparam int SCALE_REG_W = 24;
    localparam int DUTY_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // datapath widths
    localparam int AX_W    = 11;
    localparam int N_W     = 20;
    localparam int RANGE_W = 21;
    localparam int DEN_W   = 27;
    localparam int MAC_A_W = 28;
    localparam int MAC_B_W = 18;
    localparam int ACC_W   = 38;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;

    // mixer constants
    localparam int MIX_DEN       = 64000;
    localparam int THR_DEN       = 10000;
    localparam int HALF_THROTTLE = 5000;
    localparam int DUTY_MAX      = 100;
    localparam int DUTY_SAT      = DUTY_MAX + 1;
    localparam int FIXED_DEN     = MIX_DEN * DUTY_MAX;
    localparam int HI_BASE       = MIX_DEN * THR_DEN;

    // register reset values
    localparam int LIFTOFF_RESET   = 1500;
    localparam int LANDING_RESET   = 1000;
    localparam int SUM_LIMIT_RESET = 500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LANDING   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = 3'd6;

    typedef struct packed {
        logic [MOTOR_SLOTS-1:0][SCALE_REG_W-1:0] scales;
        logic [THR_W-1:0]                        liftoff;
        logic [THR_W-1:0]                        landing;
        logic [LIM_W-1:0]                        sum_limit;
    } cfg_t;

    typedef struct packed {
        logic [THR_W-1:0]        throttle;
        logic signed [SUM_W-1:0] roll_sum;
        logic signed [SUM_W-1:0] pitch_sum;
        logic signed [SUM_W-1:0] yaw_sum;
    } in_item_t;

    typedef struct packed {
        logic [MOTOR_SLOTS-1:0][DUTY_W-1:0] duty;
        logic                               reset_ctl;
        logic                               flying;
    } result_t;

    typedef struct packed {
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [ACC_W-1:0]   c;
    } mac_req_t;

endpackage

// File: rtl/core/fam_mac.sv
// fam_mac: shared signed multiply-add unit, y = c + a * b
`timescale 1ns / 1ps

module fam_mac (
    input  fam_pkg::mac_req_t                req,
    output logic signed [fam_pkg::ACC_W-1:0] y
);

    logic signed [fam_pkg::PROD_W-1:0] prod;

    assign prod = req.a * req.b;
    // every operand pair the sequencer issues keeps the product inside the accumulator
    assign y    = req.c + prod[fam_pkg::ACC_W-1:0];

endmodule

// File: rtl/core/fam_seq.sv
// fam_seq: flight mode, sequencer and working registers around the shared multiply-add unit
`timescale 1ns / 1ps

module fam_seq #(
    parameter int MOTOR_COUNT = fam_pkg::MOTOR_COUNT_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fam_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  fam_pkg::in_item_t   in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output fam_pkg::result_t    res
);

    localparam int CNT_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic [CNT_IDX_W-1:0] LAST_M = CNT_IDX_W'(MOTOR_COUNT - 1);
    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [2:0] K_START   = 3'd6;

    localparam logic signed [fam_pkg::MAC_B_W-1:0] B_THR      =
        fam_pkg::MAC_B_W'(fam_pkg::THR_DEN);
    localparam logic signed [fam_pkg::MAC_B_W-1:0] B_NEG_THR  =
        fam_pkg::MAC_B_W'(-fam_pkg::THR_DEN);
    localparam logic signed [fam_pkg::MAC_B_W-1:0] B_DUTY     =
        fam_pkg::MAC_B_W'(fam_pkg::DUTY_MAX);
    localparam logic signed [fam_pkg::MAC_B_W-1:0] B_MIX      =
        fam_pkg::MAC_B_W'(fam_pkg::MIX_DEN);
    localparam logic signed [fam_pkg::MAC_B_W-1:0] B_NEG_SAT  =
        fam_pkg::MAC_B_W'(-fam_pkg::DUTY_SAT);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_PROD   = 10'b0000000010,
        ST_DEN    = 10'b0000000100,
        ST_TERM   = 10'b0000001000,
        ST_LO     = 10'b0000010000,
        ST_HI     = 10'b0000100000,
        ST_MOTN   = 10'b0001000000,
        ST_DIVSAT = 10'b0010000000,
        ST_DIV    = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   flight_mode_reg, flight_mode_next;
    logic   was_flying_reg, was_flying_next;

    logic [fam_pkg::THR_W-1:0]        thr_reg, thr_next;
    logic signed [fam_pkg::AX_W-1:0]  ax_reg [3];
    logic signed [fam_pkg::AX_W-1:0]  ax_next [3];
    logic [CNT_IDX_W-1:0]             m_reg, m_next;
    logic [1:0]                       axis_reg, axis_next;
    logic signed [fam_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [fam_pkg::N_W-1:0]   n_reg [MOTOR_COUNT];
    logic signed [fam_pkg::N_W-1:0]   n_next [MOTOR_COUNT];
    logic signed [fam_pkg::N_W-1:0]   mn_reg, mn_next;
    logic signed [fam_pkg::N_W-1:0]   mx_reg, mx_next;
    logic [fam_pkg::DEN_W-1:0]        den_reg, den_next;
    logic signed [fam_pkg::ACC_W-1:0] term_reg, term_next;
    logic signed [fam_pkg::ACC_W-1:0] rem_reg, rem_next;
    logic [fam_pkg::DUTY_W-1:0]       q_reg, q_next;
    logic [2:0]                       k_reg, k_next;
    logic [fam_pkg::MOTOR_SLOTS-1:0][fam_pkg::DUTY_W-1:0] duty_reg, duty_next;

    fam_pkg::mac_req_t                mac_req;
    logic signed [fam_pkg::ACC_W-1:0] mac_y;
    logic [fam_pkg::RANGE_W-1:0]      range_w;
    logic                             wide;
    logic [fam_pkg::SLOT_IDX_W-1:0]   slot;
    logic signed [fam_pkg::SCALE_W-1:0] scale_byte;
    logic signed [fam_pkg::MAC_B_W-1:0] div_b;
    logic [fam_pkg::DUTY_W-1:0]       q_set;
    logic                             motor_done;
    logic [fam_pkg::DUTY_W-1:0]       motor_duty;

    function automatic logic signed [fam_pkg::AX_W-1:0] clamp_sum(
        input logic signed [fam_pkg::SUM_W-1:0] v,
        input logic [fam_pkg::LIM_W-1:0]        lim
    );
        logic signed [fam_pkg::SUM_W:0] v_s;
        logic signed [fam_pkg::SUM_W:0] lim_s;
        v_s   = (fam_pkg::SUM_W + 1)'(v);
        lim_s = $signed({{(fam_pkg::SUM_W + 1 - fam_pkg::LIM_W){1'b0}}, lim});
        if (v_s > lim_s) begin
            return fam_pkg::AX_W'(lim_s);
        end else if (v_s < -lim_s) begin
            return fam_pkg::AX_W'(-lim_s);
        end
        return fam_pkg::AX_W'(v_s);
    endfunction

    fam_mac u_mac (
        .req (mac_req),
        .y   (mac_y)
    );

    assign range_w    = fam_pkg::RANGE_W'(mx_reg) - fam_pkg::RANGE_W'(mn_reg);
    assign wide       = range_w > fam_pkg::RANGE_W'(fam_pkg::MIX_DEN);
    assign slot       = fam_pkg::SLOT_IDX_W'(m_reg);
    assign scale_byte = $signed(cfg.scales[slot][{axis_reg, 3'b000} +: fam_pkg::SCALE_W]);
    assign div_b      = fam_pkg::MAC_B_W'(0) - (fam_pkg::MAC_B_W'(1) << k_reg);
    assign q_set      = q_reg | (fam_pkg::DUTY_W'(1) << k_reg);

    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.duty      = duty_reg;
    assign res.reset_ctl = !was_flying_reg;
    assign res.flying    = was_flying_reg ? !(thr_reg < cfg.landing)
                                          : (thr_reg > cfg.liftoff);

    always_comb begin
        state_next       = state_reg;
        flight_mode_next = flight_mode_reg;
        was_flying_next  = was_flying_reg;
        thr_next         = thr_reg;
        ax_next          = ax_reg;
        m_next           = m_reg;
        axis_next        = axis_reg;
        acc_next         = acc_reg;
        n_next           = n_reg;
        mn_next          = mn_reg;
        mx_next          = mx_reg;
        den_next         = den_reg;
        term_next        = term_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        k_next           = k_reg;
        duty_next        = duty_reg;
        mac_req          = '0;
        motor_done       = 1'b0;
        motor_duty       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    thr_next        = in_item.throttle;
                    ax_next[0]      = clamp_sum(in_item.roll_sum, cfg.sum_limit);
                    ax_next[1]      = clamp_sum(in_item.pitch_sum, cfg.sum_limit);
                    ax_next[2]      = clamp_sum(in_item.yaw_sum, cfg.sum_limit);
                    was_flying_next = flight_mode_reg;
                    duty_next       = '0;
                    m_next          = '0;
                    axis_next       = '0;
                    acc_next        = '0;
                    mn_next         = '0;
                    mx_next         = '0;
                    state_next      = flight_mode_reg ? ST_PROD : ST_DONE;
                end
            end
            ST_PROD: begin
                // accumulate one axis product of the current motor
                mac_req.a = fam_pkg::MAC_A_W'(ax_reg[axis_reg]);
                mac_req.b = fam_pkg::MAC_B_W'(scale_byte);
                mac_req.c = acc_reg;
                acc_next  = mac_y;
                if (axis_reg == AXIS_LAST) begin
                    n_next[m_reg] = fam_pkg::N_W'(mac_y);
                    if (mac_y < fam_pkg::ACC_W'(mn_reg)) begin
                        mn_next = fam_pkg::N_W'(mac_y);
                    end
                    if (mac_y > fam_pkg::ACC_W'(mx_reg)) begin
                        mx_next = fam_pkg::N_W'(mac_y);
                    end
                    acc_next  = '0;
                    axis_next = '0;
                    if (m_reg == LAST_M) begin
                        m_next     = '0;
                        state_next = ST_DEN;
                    end else begin
                        m_next = m_reg + 1'b1;
                    end
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_DEN: begin
                if (wide) begin
                    mac_req.a = fam_pkg::MAC_A_W'(range_w);
                    mac_req.b = B_DUTY;
                    den_next  = fam_pkg::DEN_W'(mac_y);
                end else begin
                    den_next = fam_pkg::DEN_W'(fam_pkg::FIXED_DEN);
                end
                state_next = ST_TERM;
            end
            ST_TERM: begin
                if (wide) begin
                    mac_req.a  = fam_pkg::MAC_A_W'(range_w);
                    mac_req.b  = fam_pkg::MAC_B_W'(thr_reg);
                    term_next  = mac_y;
                    state_next = ST_MOTN;
                end else begin
                    mac_req.a = fam_pkg::MAC_A_W'(thr_reg);
                    mac_req.b = B_MIX;
                    term_next = mac_y;
                    if (thr_reg > fam_pkg::THR_W'(fam_pkg::HALF_THROTTLE)) begin
                        state_next = ST_LO;
                    end else begin
                        state_next = ST_MOTN;
                    end
                end
            end
            ST_LO: begin
                // lower bound -min * 10000
                mac_req.a = fam_pkg::MAC_A_W'(mn_reg);
                mac_req.b = B_NEG_THR;
                if (term_reg < mac_y) begin
                    term_next  = mac_y;
                    state_next = ST_MOTN;
                end else begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                // upper bound (64000 - max) * 10000
                mac_req.a = fam_pkg::MAC_A_W'(mx_reg);
                mac_req.b = B_NEG_THR;
                mac_req.c = fam_pkg::ACC_W'(fam_pkg::HI_BASE);
                if (term_reg > mac_y) begin
                    term_next = mac_y;
                end
                state_next = ST_MOTN;
            end
            ST_MOTN: begin
                mac_req.a  = fam_pkg::MAC_A_W'(n_reg[m_reg]);
                mac_req.b  = B_THR;
                mac_req.c  = term_reg;
                rem_next   = mac_y;
                state_next = ST_DIVSAT;
            end
            ST_DIVSAT: begin
                // negative numerator truncates to zero, 101 denominators or more saturate
                mac_req.a = fam_pkg::MAC_A_W'(den_reg);
                mac_req.b = B_NEG_SAT;
                mac_req.c = rem_reg;
                if (rem_reg[fam_pkg::ACC_W-1]) begin
                    motor_done = 1'b1;
                    motor_duty = '0;
                end else if (!mac_y[fam_pkg::ACC_W-1]) begin
                    motor_done = 1'b1;
                    motor_duty = fam_pkg::DUTY_W'(fam_pkg::DUTY_MAX);
                end else begin
                    q_next     = '0;
                    k_next     = K_START;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                mac_req.a = fam_pkg::MAC_A_W'(den_reg);
                mac_req.b = div_b;
                mac_req.c = rem_reg;
                if (!mac_y[fam_pkg::ACC_W-1]) begin
                    rem_next = mac_y;
                    q_next   = q_set;
                end
                if (k_reg == 3'd0) begin
                    motor_done = 1'b1;
                    motor_duty = mac_y[fam_pkg::ACC_W-1] ? q_reg : q_set;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    flight_mode_next = res.flying;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (motor_done) begin
            duty_next[slot] = motor_duty;
            if (m_reg == LAST_M) begin
                state_next = ST_DONE;
            end else begin
                m_next     = m_reg + 1'b1;
                state_next = ST_MOTN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            flight_mode_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            flight_mode_reg <= flight_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        was_flying_reg <= was_flying_next;
        thr_reg        <= thr_next;
        ax_reg         <= ax_next;
        m_reg          <= m_next;
        axis_reg       <= axis_next;
        acc_reg        <= acc_next;
        n_reg          <= n_next;
        mn_reg         <= mn_next;
        mx_reg         <= mx_next;
        den_reg        <= den_next;
        term_reg       <= term_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        k_reg          <= k_next;
        duty_reg       <= duty_next;
    end

    // an accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    // a grounded tick reports all duties zero
    a_grounded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !was_flying_reg) |-> (res.duty == '0))
        else $error("grounded tick with nonzero duty");

    // division never starts above the top quotient bit
    a_div_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (k_reg <= K_START))
        else $error("division step out of range");

    // a taken result frees the block on the next cycle
    a_done_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_ready) |=> (state_reg == ST_IDLE))
        else $error("result taken but block still busy");

endmodule

// File: rtl/core/flight_arming_motor_mixer_unit.sv
// flight_arming_motor_mixer_unit: top level with register file, sequencer and result register
`timescale 1ns / 1ps

// Arming state machine and motor mixer for a multirotor, one item per control tick.
// A grounded tick skips the mixer and goes from idle directly to the done state; a flying tick
// runs on the one shared multiply-add unit: three mix products per motor, the denominator
// and throttle terms with up to two throttle bound checks, then per motor the numerator,
// a saturation check and, unless the duty comes out zero or full, seven restoring
// division steps. s_ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next item can be taken while it waits.
// Configuration writes are always accepted (cfg_ready stays high) and must only be
// issued while no item is in flight; indexes beyond the register list are dropped.
module flight_arming_motor_mixer_unit #(
    parameter int MOTOR_COUNT = fam_pkg::MOTOR_COUNT_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fam_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fam_pkg::THR_W-1:0]         s_throttle,
    input  logic signed [fam_pkg::SUM_W-1:0]  s_roll_sum,
    input  logic signed [fam_pkg::SUM_W-1:0]  s_pitch_sum,
    input  logic signed [fam_pkg::SUM_W-1:0]  s_yaw_sum,
    // result item channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fam_pkg::DUTY_W-1:0]        m_duty_motor0,
    output logic [fam_pkg::DUTY_W-1:0]        m_duty_motor1,
    output logic [fam_pkg::DUTY_W-1:0]        m_duty_motor2,
    output logic [fam_pkg::DUTY_W-1:0]        m_duty_motor3,
    output logic                              m_reset_controllers,
    output logic                              m_is_flying
);

    // register file
    logic [fam_pkg::MOTOR_SLOTS-1:0][fam_pkg::SCALE_REG_W-1:0] scales_reg;
    logic [fam_pkg::THR_W-1:0] liftoff_reg;
    logic [fam_pkg::THR_W-1:0] landing_reg;
    logic [fam_pkg::LIM_W-1:0] sum_limit_reg;
    fam_pkg::cfg_t             cfg;

    // sequencer handshake
    fam_pkg::in_item_t in_item;
    fam_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;

    // output register
    logic             m_valid_reg;
    fam_pkg::result_t out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scales_reg    <= '0;
            liftoff_reg   <= fam_pkg::THR_W'(fam_pkg::LIFTOFF_RESET);
            landing_reg   <= fam_pkg::THR_W'(fam_pkg::LANDING_RESET);
            sum_limit_reg <= fam_pkg::LIM_W'(fam_pkg::SUM_LIMIT_RESET);
        end else if (cfg_valid) begin
            case (cfg_index) inside
                [fam_pkg::REG_MOTOR0:fam_pkg::REG_MOTOR3]: begin
                    scales_reg[cfg_index[fam_pkg::SLOT_IDX_W-1:0]] <=
                        cfg_data[fam_pkg::SCALE_REG_W-1:0];
                end
                fam_pkg::REG_LIFTOFF: begin
                    liftoff_reg <= cfg_data[fam_pkg::THR_W-1:0];
                end
                fam_pkg::REG_LANDING: begin
                    landing_reg <= cfg_data[fam_pkg::THR_W-1:0];
                end
                fam_pkg::REG_SUM_LIMIT: begin
                    sum_limit_reg <= cfg_data[fam_pkg::LIM_W-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign cfg.scales    = scales_reg;
    assign cfg.liftoff   = liftoff_reg;
    assign cfg.landing   = landing_reg;
    assign cfg.sum_limit = sum_limit_reg;

    assign in_item.throttle  = s_throttle;
    assign in_item.roll_sum  = s_roll_sum;
    assign in_item.pitch_sum = s_pitch_sum;
    assign in_item.yaw_sum   = s_yaw_sum;

    // sequencer owns the flight mode and all working registers
    fam_seq #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register frees the sequencer as soon as the slot is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_duty_motor0       = out_reg.duty[0];
    assign m_duty_motor1       = out_reg.duty[1];
    assign m_duty_motor2       = out_reg.duty[2];
    assign m_duty_motor3       = out_reg.duty[3];
    assign m_reset_controllers = out_reg.reset_ctl;
    assign m_is_flying         = out_reg.flying;

endmodule

// File: dv/tb.sv
// tb: self-checking bench for the arming state machine and motor mixer, with its own mixer model
`timescale 1ns / 1ps

module tb;

    // bench sizing
    localparam int N_MOTORS      = fam_pkg::MOTOR_COUNT_DEFAULT;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES  = 80;    // settle time after the last tick is answered
    localparam int PHASE_TICKS   = 160;
    localparam int THR_FIELD_MAX = (1 << fam_pkg::THR_W) - 1;

    // index past the register list, the block must drop it
    localparam logic [fam_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // one planned step: either a register write or a control tick
    typedef struct {
        bit                              is_write;
        logic [fam_pkg::CFG_IDX_W-1:0]   idx;
        logic [fam_pkg::CFG_DATA_W-1:0]  data;
        fam_pkg::in_item_t               tick;
        int                              pace;   // idle percentage while this item is around
        bit                              hold;   // start the long receiver hold-off when issued
    } plan_t;

    logic aclk;
    logic aresetn = 1'b0;

    // configuration channel
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fam_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // tick input channel
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic [fam_pkg::THR_W-1:0]        s_throttle  = '0;
    logic signed [fam_pkg::SUM_W-1:0] s_roll_sum  = '0;
    logic signed [fam_pkg::SUM_W-1:0] s_pitch_sum = '0;
    logic signed [fam_pkg::SUM_W-1:0] s_yaw_sum   = '0;

    // duty output channel
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [fam_pkg::DUTY_W-1:0] m_duty_motor0;
    logic [fam_pkg::DUTY_W-1:0] m_duty_motor1;
    logic [fam_pkg::DUTY_W-1:0] m_duty_motor2;
    logic [fam_pkg::DUTY_W-1:0] m_duty_motor3;
    logic                       m_reset_controllers;
    logic                       m_is_flying;

    flight_arming_motor_mixer_unit #(
        .MOTOR_COUNT (N_MOTORS)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_throttle          (s_throttle),
        .s_roll_sum          (s_roll_sum),
        .s_pitch_sum         (s_pitch_sum),
        .s_yaw_sum           (s_yaw_sum),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_duty_motor0       (m_duty_motor0),
        .m_duty_motor1       (m_duty_motor1),
        .m_duty_motor2       (m_duty_motor2),
        .m_duty_motor3       (m_duty_motor3),
        .m_reset_controllers (m_reset_controllers),
        .m_is_flying         (m_is_flying)
    );

    // ------------------------------------------------------------------
    // mixer model state: register copies and the grounded/flying flag
    // ------------------------------------------------------------------
    logic [fam_pkg::SCALE_REG_W-1:0] scale_reg [fam_pkg::MOTOR_SLOTS];
    logic [fam_pkg::THR_W-1:0]       liftoff_reg   = fam_pkg::THR_W'(fam_pkg::LIFTOFF_RESET);
    logic [fam_pkg::THR_W-1:0]       landing_reg   = fam_pkg::THR_W'(fam_pkg::LANDING_RESET);
    logic [fam_pkg::LIM_W-1:0]       sum_limit_reg = fam_pkg::LIM_W'(fam_pkg::SUM_LIMIT_RESET);
    logic                            flying_st     = 1'b0;

    // expected duty items, oldest first
    fam_pkg::result_t duty_expect_q [$];

    // coverage-style tallies for the closing summary
    int n_flying_ticks = 0;
    int n_normalized   = 0;
    int n_thr_clamped  = 0;
    int n_reg_writes   = 0;
    int fails          = 0;

    // driver bookkeeping, shared with the run control below
    fam_pkg::in_item_t live_tick;
    int                live_pace = 0;
    int                gap_cnt   = 0;
    int                ticks_in  = 0;
    int                ticks_out = 0;
    int                rx_pace   = 0;      // receiver idle rate, follows the tick being sent
    logic              hold_req  = 1'b0;

    initial begin
        for (int m = 0; m < fam_pkg::MOTOR_SLOTS; m++) scale_reg[m] = '0;
    end

    // register write as the block should see it; unknown indexes are dropped
    function automatic void load_reg(logic [fam_pkg::CFG_IDX_W-1:0] idx,
                                     logic [fam_pkg::CFG_DATA_W-1:0] d);
        n_reg_writes++;
        if (idx >= fam_pkg::REG_MOTOR0 && idx <= fam_pkg::REG_MOTOR3)
            scale_reg[fam_pkg::SLOT_IDX_W'(idx - fam_pkg::REG_MOTOR0)] =
                d[fam_pkg::SCALE_REG_W-1:0];
        else if (idx == fam_pkg::REG_LIFTOFF)
            liftoff_reg = d[fam_pkg::THR_W-1:0];
        else if (idx == fam_pkg::REG_LANDING)
            landing_reg = d[fam_pkg::THR_W-1:0];
        else if (idx == fam_pkg::REG_SUM_LIMIT)
            sum_limit_reg = d[fam_pkg::LIM_W-1:0];
    endfunction

    // truncate toward zero, then saturate to 0..100
    function automatic logic [fam_pkg::DUTY_W-1:0] duty_pct(longint num, longint den);
        longint q;
        q = num / den;
        if (q < 0) q = 0;
        if (q > fam_pkg::DUTY_MAX) q = fam_pkg::DUTY_MAX;
        return q[fam_pkg::DUTY_W-1:0];
    endfunction

    // one control tick: flight-mode hysteresis plus the exact-rational mixer.
    // the mix of motor m is held as numerator mix_n[m] over MIX_DEN, throttle
    // as thr over THR_DEN; only the final division rounds
    function automatic fam_pkg::result_t mix_tick(fam_pkg::in_item_t it);
        fam_pkg::result_t                   r;
        longint                             ax [3];
        longint                             mix_n [fam_pkg::MOTOR_SLOTS];
        longint                             lo_n, hi_n, spread, thr, thr_n, lim, acc;
        longint                             lo_t, hi_t;
        logic signed [fam_pkg::SCALE_W-1:0] q;
        r = '0;
        r.reset_ctl = !flying_st;
        if (!flying_st) begin
            // grounded: duties stay zero, only the liftoff check runs
            if (it.throttle > liftoff_reg) flying_st = 1'b1;
            r.flying = flying_st;
            return r;
        end
        n_flying_ticks++;

        // symmetric clamp on each PID sum
        lim   = longint'(sum_limit_reg);
        ax[0] = longint'($signed(it.roll_sum));
        ax[1] = longint'($signed(it.pitch_sum));
        ax[2] = longint'($signed(it.yaw_sum));
        for (int a = 0; a < 3; a++) begin
            if (ax[a] < -lim) ax[a] = -lim;
            else if (ax[a] > lim) ax[a] = lim;
        end

        // per-motor mix; min and max start at zero
        lo_n = 0;
        hi_n = 0;
        for (int m = 0; m < N_MOTORS; m++) begin
            acc = 0;
            for (int a = 0; a < 3; a++) begin
                q = scale_reg[m][a*fam_pkg::SCALE_W +: fam_pkg::SCALE_W];
                acc += ax[a] * longint'(q);
            end
            mix_n[m] = acc;
            if (acc < lo_n) lo_n = acc;
            if (acc > hi_n) hi_n = acc;
        end

        spread = hi_n - lo_n;
        thr    = longint'(it.throttle);
        if (spread > fam_pkg::MIX_DEN) begin
            // range above one: normalize the mix, throttle taken as is
            n_normalized++;
            for (int m = 0; m < N_MOTORS; m++)
                r.duty[m] = duty_pct(mix_n[m] * fam_pkg::THR_DEN + thr * spread,
                                     spread * fam_pkg::DUTY_MAX);
        end else begin
            // throttle over the common denominator MIX_DEN * THR_DEN
            thr_n = thr * fam_pkg::MIX_DEN;
            if (it.throttle > fam_pkg::HALF_THROTTLE) begin
                lo_t = -lo_n * fam_pkg::THR_DEN;
                hi_t = (longint'(fam_pkg::MIX_DEN) - hi_n) * fam_pkg::THR_DEN;
                if (thr_n < lo_t) begin
                    thr_n = lo_t;
                    n_thr_clamped++;
                end else if (thr_n > hi_t) begin
                    thr_n = hi_t;
                    n_thr_clamped++;
                end
            end
            for (int m = 0; m < N_MOTORS; m++)
                r.duty[m] = duty_pct(mix_n[m] * fam_pkg::THR_DEN + thr_n,
                                     longint'(fam_pkg::MIX_DEN) * fam_pkg::DUTY_MAX);
        end

        if (it.throttle < landing_reg) flying_st = 1'b0;
        r.flying = flying_st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus plan, filled once at time zero
    // ------------------------------------------------------------------
    plan_t plan_q [$];
    int    plan_pace = 0;
    bit    plan_hold = 1'b0;

    // register values as planned, so the tick generator aims at the thresholds
    int pl_liftoff = fam_pkg::LIFTOFF_RESET;
    int pl_landing = fam_pkg::LANDING_RESET;
    int pl_limit   = fam_pkg::SUM_LIMIT_RESET;

    function automatic logic [fam_pkg::SCALE_REG_W-1:0] pack3(int roll, int pitch, int yaw);
        return {yaw[fam_pkg::SCALE_W-1:0], pitch[fam_pkg::SCALE_W-1:0],
                roll[fam_pkg::SCALE_W-1:0]};
    endfunction

    task automatic plan_write(logic [fam_pkg::CFG_IDX_W-1:0] idx,
                              logic [fam_pkg::CFG_DATA_W-1:0] d);
        plan_t e;
        e = '{default: '0};
        e.is_write = 1'b1;
        e.idx      = idx;
        e.data     = d;
        e.pace     = plan_pace;
        if (idx == fam_pkg::REG_LIFTOFF)   pl_liftoff = int'(d[fam_pkg::THR_W-1:0]);
        if (idx == fam_pkg::REG_LANDING)   pl_landing = int'(d[fam_pkg::THR_W-1:0]);
        if (idx == fam_pkg::REG_SUM_LIMIT) pl_limit   = int'(d[fam_pkg::LIM_W-1:0]);
        plan_q.push_back(e);
    endtask

    task automatic plan_tick(int thr, int roll, int pitch, int yaw);
        plan_t e;
        e = '{default: '0};
        e.tick.throttle  = thr[fam_pkg::THR_W-1:0];
        e.tick.roll_sum  = roll[fam_pkg::SUM_W-1:0];
        e.tick.pitch_sum = pitch[fam_pkg::SUM_W-1:0];
        e.tick.yaw_sum   = yaw[fam_pkg::SUM_W-1:0];
        e.pace           = plan_pace;
        e.hold           = plan_hold;
        plan_hold        = 1'b0;
        plan_q.push_back(e);
    endtask

    // full set of seven registers for one setting
    task automatic plan_config(logic [fam_pkg::SCALE_REG_W-1:0] s0,
                               logic [fam_pkg::SCALE_REG_W-1:0] s1,
                               logic [fam_pkg::SCALE_REG_W-1:0] s2,
                               logic [fam_pkg::SCALE_REG_W-1:0] s3,
                               int lift, int land, int lim);
        plan_write(fam_pkg::REG_MOTOR0,        s0);
        plan_write(fam_pkg::REG_MOTOR0 + 3'd1, s1);
        plan_write(fam_pkg::REG_MOTOR0 + 3'd2, s2);
        plan_write(fam_pkg::REG_MOTOR3,        s3);
        plan_write(fam_pkg::REG_LIFTOFF,       lift[fam_pkg::CFG_DATA_W-1:0]);
        plan_write(fam_pkg::REG_LANDING,       land[fam_pkg::CFG_DATA_W-1:0]);
        plan_write(fam_pkg::REG_SUM_LIMIT,     lim[fam_pkg::CFG_DATA_W-1:0]);
    endtask

    function automatic logic [fam_pkg::SCALE_REG_W-1:0] rand_scales();
        if ($urandom_range(1) == 0)
            return fam_pkg::SCALE_REG_W'($urandom_range(24'hFFFFFF, 0));
        return pack3(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                     int'($urandom_range(128)) - 64);
    endfunction

    task automatic plan_random_config();
        int lift, land, lim;
        lift = $urandom_range(3000, 200);
        land = ($urandom_range(7) == 0) ? $urandom_range(lift + 500, lift)
                                        : $urandom_range(lift, 0);
        lim  = ($urandom_range(3) == 0) ? 1000 : $urandom_range(1000, 0);
        plan_config(rand_scales(), rand_scales(), rand_scales(), rand_scales(), lift, land, lim);
    endtask

    // PID sum: mostly near the clamp, some full-width noise and extremes
    function automatic int rand_sum();
        int                               k;
        logic signed [fam_pkg::SUM_W-1:0] w;
        k = $urandom_range(99);
        if (k < 30) begin
            w = fam_pkg::SUM_W'($urandom);
            return w;
        end
        if (k < 75) return int'($urandom_range(2 * pl_limit + 100, 0)) - pl_limit - 50;
        if (k < 85) begin
            case ($urandom_range(5))
                0:       return 32767;
                1:       return -32768;
                2:       return pl_limit;
                3:       return -pl_limit;
                4:       return pl_limit + 1;
                default: return -pl_limit - 1;
            endcase
        end
        return int'($urandom_range(100)) - 50;
    endfunction

    // throttle while airborne: at or above landing, some around half throttle
    function automatic int fly_throttle();
        int k;
        k = $urandom_range(99);
        if (k < 10) return $urandom_range(THR_FIELD_MAX, pl_landing);
        if (k < 22 && pl_landing <= 4997) return $urandom_range(5003, 4997);
        if (pl_landing <= fam_pkg::THR_DEN) return $urandom_range(fam_pkg::THR_DEN, pl_landing);
        return $urandom_range(THR_FIELD_MAX, pl_landing);
    endfunction

    // mostly whole flights (sit, lift off, fly, maybe land), some pure noise
    task automatic plan_flights(int n_ticks);
        int left;
        left = n_ticks;
        while (left > 0) begin
            if ($urandom_range(99) < 12) begin
                plan_tick($urandom_range(THR_FIELD_MAX, 0), rand_sum(), rand_sum(), rand_sum());
                left--;
            end else begin
                repeat ($urandom_range(2, 1)) begin
                    plan_tick($urandom_range(pl_liftoff, 0), rand_sum(), rand_sum(), rand_sum());
                    left--;
                end
                if (pl_liftoff < THR_FIELD_MAX) begin
                    plan_tick($urandom_range(THR_FIELD_MAX, pl_liftoff + 1),
                              rand_sum(), rand_sum(), rand_sum());
                    left--;
                end
                repeat ($urandom_range(24, 3)) begin
                    plan_tick(fly_throttle(), rand_sum(), rand_sum(), rand_sum());
                    left--;
                end
                if (pl_landing > 0 && $urandom_range(3) != 0) begin
                    plan_tick($urandom_range(pl_landing - 1, 0),
                              rand_sum(), rand_sum(), rand_sum());
                    left--;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // clock, reset and the run itself
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        // directed ticks at reset settings: all scales zero, so duty follows throttle
        plan_pace = 20;
        plan_tick(0, 0, 0, 0);                          // grounded, controllers held in reset
        plan_tick(1500, 32767, -32768, 32767);          // at liftoff threshold, no liftoff
        plan_tick(1501, 0, 0, 0);                       // just above, lifts off
        plan_tick(THR_FIELD_MAX, 32767, 32767, 32767);  // throttle beyond full scale

        // X mix at unit scales; the unmapped index must not disturb anything
        plan_config(pack3(-64, 64, -64), pack3(64, 64, 64), pack3(64, -64, -64),
                    pack3(-64, -64, 64), fam_pkg::LIFTOFF_RESET, fam_pkg::LANDING_RESET,
                    fam_pkg::SUM_LIMIT_RESET);
        plan_write(REG_UNMAPPED, 24'hFFFFFF);
        plan_tick(5000, 100, 0, 0);                     // half throttle, no clamping
        plan_tick(5001, 100, 0, 0);                     // just above half, clamp window open
        plan_tick(10000, 200, 0, 0);                    // throttle clamped at the top
        plan_tick(6000, 500, 500, 500);                 // range above one, mix normalized
        plan_tick(5001, 0, 0, 500);                     // range exactly one, not normalized
        plan_tick(2000, -32768, 32767, -1);             // sums clamped both ways
        plan_tick(1000, 0, 0, 0);                       // at landing threshold, stays up
        plan_tick(999, 0, 0, 0);                        // just below, lands
        plan_tick(999, 0, 0, 0);                        // grounded again

        // lopsided scales at the byte extremes, widest thresholds
        plan_config(pack3(-64, 0, 0), 24'h000000, pack3(0, 0, 127), pack3(0, -128, 0),
                    fam_pkg::THR_DEN, 0, 1000);
        plan_tick(fam_pkg::THR_DEN, 0, 0, 0);           // at liftoff, no liftoff
        plan_tick(fam_pkg::THR_DEN + 1, 0, 0, 0);       // lifts off
        plan_tick(5001, 600, 0, 0);                     // throttle raised to the low bound
        plan_tick(10000, 0, 1000, -1000);               // normalized, negative side
        plan_tick(8000, 0, 0, 1000);                    // normalized, positive side
        plan_tick(3000, -32768, 32767, -32768);         // clamped at the widest limit
        plan_tick(0, 0, 0, 0);                          // landing at zero never lands

        // random phases, each with its own setting and idle rate
        plan_pace = 20;
        plan_config(pack3(-64, 64, -64), pack3(64, 64, 64), pack3(64, -64, -64),
                    pack3(-64, -64, 64), fam_pkg::LIFTOFF_RESET, fam_pkg::LANDING_RESET,
                    fam_pkg::SUM_LIMIT_RESET);
        plan_flights(PHASE_TICKS);

        plan_pace = 0;   // extreme scales, liftoff and landing at zero
        plan_config(24'h7F7F7F, 24'h808080, 24'h7F8080, 24'h807F7F, 0, 0, 1000);
        plan_flights(PHASE_TICKS);

        plan_pace = 40;  // zero sum limit, top thresholds
        plan_config(rand_scales(), rand_scales(), rand_scales(), rand_scales(),
                    fam_pkg::THR_DEN, fam_pkg::THR_DEN, 0);
        plan_flights(PHASE_TICKS);

        plan_pace = 10;  // sum limit at the field maximum, above its nominal range
        plan_config(rand_scales(), rand_scales(), rand_scales(), rand_scales(),
                    3000, 2500, (1 << fam_pkg::LIM_W) - 1);
        plan_flights(PHASE_TICKS);

        plan_pace = 25;  // long hold-off on the result side midway through
        plan_random_config();
        plan_flights(PHASE_TICKS / 2);
        plan_hold = 1'b1;
        plan_flights(PHASE_TICKS / 2);

        plan_pace = 60;
        plan_random_config();
        plan_write(REG_UNMAPPED, fam_pkg::CFG_DATA_W'($urandom_range(24'hFFFFFF, 0)));
        plan_flights(PHASE_TICKS);

        plan_pace = 15;
        plan_random_config();
        plan_flights(PHASE_TICKS);

        plan_pace = 0;   // tail runs at full rate on both sides
        plan_random_config();
        plan_flights(PHASE_TICKS);

        // synchronous reset, held from time zero and released once
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: everything issued, every tick answered, then let the pipe settle
        @(negedge aclk);
        while (plan_q.size() != 0 || s_valid || cfg_valid || ticks_in != ticks_out)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (duty_expect_q.size() != 0) begin
            $error("%0d duty items never arrived", duty_expect_q.size());
            fails++;
        end

        $display("covered %0d ticks (%0d flying, %0d normalized, %0d throttle-clamped)",
                 ticks_in, n_flying_ticks, n_normalized, n_thr_clamped);
        $display("with %0d register writes, one %0d-cycle result hold-off, %0d mismatches",
                 n_reg_writes, HOLD_CYCLES, fails);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial begin
        #(10_000_000);
        $display("timed out with %0d ticks outstanding", ticks_in - ticks_out);
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: issues planned ticks and register writes; writes wait for idle
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        bit    tick_on;
        bit    write_on;
        bit    pulse;
        plan_t nx;
        tick_on  = s_valid && !s_ready;
        write_on = cfg_valid && !cfg_ready;
        pulse    = 1'b0;
        if (!aresetn) begin
            tick_on  = 1'b0;
            write_on = 1'b0;
        end else begin
            // tick taken: predict its duties now, against the current settings
            if (s_valid && s_ready) begin
                duty_expect_q.push_back(mix_tick(live_tick));
                ticks_in++;
                if ($urandom_range(99) < live_pace) gap_cnt = $urandom_range(16, 1);
            end
            if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) ticks_out++;

            if (!tick_on && !write_on) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (plan_q.size() != 0) begin
                    nx = plan_q[0];
                    if (!nx.is_write) begin
                        void'(plan_q.pop_front());
                        tick_on     = 1'b1;
                        live_tick   = nx.tick;
                        live_pace   = nx.pace;
                        pulse       = nx.hold;
                        rx_pace     <= nx.pace;
                        s_throttle  <= nx.tick.throttle;
                        s_roll_sum  <= nx.tick.roll_sum;
                        s_pitch_sum <= nx.tick.pitch_sum;
                        s_yaw_sum   <= nx.tick.yaw_sum;
                    end else if (ticks_in == ticks_out) begin
                        // block idle: every tick so far has been answered
                        void'(plan_q.pop_front());
                        write_on  = 1'b1;
                        cfg_index <= nx.idx;
                        cfg_data  <= nx.data;
                    end
                end
            end
        end
        s_valid   <= tick_on;
        cfg_valid <= write_on;
        hold_req  <= pulse;
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure and field-by-field duty check
    // ------------------------------------------------------------------
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge aclk) begin : monitor
        bit               rdy;
        fam_pkg::result_t got;
        fam_pkg::result_t want;
        rdy = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got           = '0;
                got.duty[0]   = m_duty_motor0;
                got.duty[1]   = m_duty_motor1;
                got.duty[2]   = m_duty_motor2;
                got.duty[3]   = m_duty_motor3;
                got.reset_ctl = m_reset_controllers;
                got.flying    = m_is_flying;
                if (duty_expect_q.size() == 0) begin
                    $error("duty item with no tick pending");
                    fails++;
                end else begin
                    want = duty_expect_q.pop_front();
                    for (int m = 0; m < fam_pkg::MOTOR_SLOTS; m++) begin
                        if (got.duty[m] !== want.duty[m]) begin
                            $error("duty_motor%0d: expected %0d, got %0d",
                                   m, want.duty[m], got.duty[m]);
                            fails++;
                        end
                    end
                    if (got.reset_ctl !== want.reset_ctl) begin
                        $error("reset_controllers: expected %0d, got %0d",
                               want.reset_ctl, got.reset_ctl);
                        fails++;
                    end
                    if (got.flying !== want.flying) begin
                        $error("is_flying: expected %0d, got %0d", want.flying, got.flying);
                        fails++;
                    end
                end
            end

            // long hold-off first, then short random bursts at the current rate
            if (hold_req) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (rx_pace != 0 && $urandom_range(99) < rx_pace) begin
                stall_left = $urandom_range(16, 1) - 1;
            end else begin
                rdy = 1'b1;
            end
        end
        m_ready <= rdy;
    end

endmodule
